// ===== rtl/lpfp_pkg.sv =====
`default_nettype none

package lpfp_pkg;

    // Frame layout: the length word counts these header words too.
    localparam int unsigned HEADER_WORDS = 4;
    localparam int unsigned HDR_BYTES    = HEADER_WORDS * 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_SIGNATURE = 2'd0;
    localparam logic [1:0] CFG_COMPRESSED_CODE    = 2'd1;
    localparam logic [1:0] CFG_OWN_VERSION        = 2'd2;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_BAD_LENGTH  = 2'd1;
    localparam logic [1:0] ERR_BAD_SIG     = 2'd2;
    localparam logic [1:0] ERR_OLD_VERSION = 2'd3;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic        compressed;
        logic [30:0] payload_length;
        logic [1:0]  error_code;
        logic [31:0] required_version;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lpfp_parser.sv =====
`default_nettype none

module lpfp_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_restart,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    output logic                 o_res_valid,
    output lpfp_pkg::t_result    o_res
);
    import lpfp_pkg::*;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    logic [31:0] r_expected_signature;
    logic [31:0] r_compressed_code;
    logic [31:0] r_own_version;

    logic [1:0]  r_phase,      n_phase;
    logic [3:0]  r_byte_index, n_byte_index;
    logic [31:0] r_shift,      n_shift;
    logic [30:0] r_remaining,  n_remaining;
    logic [30:0] r_frame_len,  n_frame_len;
    logic        r_sig_bad,    n_sig_bad;
    logic        r_comp,       n_comp;

    logic [31:0] w_word;
    logic [31:0] w_plen;
    logic [30:0] w_rem_dec;

    assign w_word    = {r_shift[23:0], i_data_byte};
    assign w_plen    = w_word - 32'(HDR_BYTES);
    assign w_rem_dec = r_remaining - 31'd1;

    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_shift      = r_shift;
        n_remaining  = r_remaining;
        n_frame_len  = r_frame_len;
        n_sig_bad    = r_sig_bad;
        n_comp       = r_comp;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_take) begin
            if (i_restart) begin
                n_phase      = PH_LEN;
                n_byte_index = '0;
                n_shift      = '0;
                n_remaining  = '0;
                n_frame_len  = '0;
                n_sig_bad    = 1'b0;
                n_comp       = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_LEN: begin
                        n_shift = w_word;
                        if (r_byte_index < 4'd3) begin
                            n_byte_index = r_byte_index + 4'd1;
                        end else if (w_plen == 32'd0 || w_plen[31]) begin
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_BAD_LENGTH;
                            n_phase           = PH_HALT;
                            n_byte_index      = '0;
                        end else begin
                            n_frame_len  = w_plen[30:0];
                            n_phase      = PH_HDR;
                            n_byte_index = '0;
                            n_sig_bad    = 1'b0;
                            n_comp       = 1'b0;
                        end
                    end
                    PH_HDR: begin
                        n_shift      = w_word;
                        n_byte_index = r_byte_index + 4'd1;
                        if (r_byte_index[1:0] == 2'd3) begin
                            unique case (r_byte_index[3:2])
                                2'd0: n_sig_bad = (w_word != r_expected_signature);
                                2'd1: n_comp    = (w_word == r_compressed_code);
                                2'd2: ;
                                default: begin
                                    // final header word: minimum version
                                    n_byte_index = '0;
                                    if (r_sig_bad) begin
                                        o_res_valid       = 1'b1;
                                        o_res.result_kind = KIND_ERROR;
                                        o_res.error_code  = ERR_BAD_SIG;
                                        n_phase           = PH_HALT;
                                    end else if (w_word > r_own_version) begin
                                        o_res_valid            = 1'b1;
                                        o_res.result_kind      = KIND_ERROR;
                                        o_res.error_code       = ERR_OLD_VERSION;
                                        o_res.required_version = w_word;
                                        n_phase                = PH_HALT;
                                    end else begin
                                        n_phase     = PH_PAY;
                                        n_remaining = r_frame_len;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_PAY: begin
                        n_remaining          = w_rem_dec;
                        o_res_valid          = 1'b1;
                        o_res.result_kind    = KIND_PAYLOAD;
                        o_res.payload_byte   = i_data_byte;
                        o_res.last_byte      = (w_rem_dec == 31'd0);
                        o_res.compressed     = r_comp;
                        o_res.payload_length = r_frame_len;
                        o_res.error_code     = ERR_NONE;
                        if (w_rem_dec == 31'd0) begin
                            n_phase      = PH_LEN;
                            n_byte_index = '0;
                            n_shift      = '0;
                        end
                    end
                    default: ; // halted: drop bytes until restart
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase              <= PH_LEN;
            r_byte_index         <= '0;
            r_shift              <= '0;
            r_remaining          <= '0;
            r_frame_len          <= '0;
            r_sig_bad            <= 1'b0;
            r_comp               <= 1'b0;
            r_expected_signature <= '0;
            r_compressed_code    <= '0;
            r_own_version        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_shift      <= n_shift;
            r_remaining  <= n_remaining;
            r_frame_len  <= n_frame_len;
            r_sig_bad    <= n_sig_bad;
            r_comp       <= n_comp;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_EXPECTED_SIGNATURE: r_expected_signature <= i_cfg_data;
                    CFG_COMPRESSED_CODE:    r_compressed_code    <= i_cfg_data;
                    CFG_OWN_VERSION:        r_own_version        <= i_cfg_data;
                    default: ; // index beyond the list: drop
                endcase
            end
        end
    end

    a_len_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LEN |-> r_byte_index <= 4'd3)
        else $error("byte index out of range in length phase");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.result_kind == KIND_ERROR |=> r_phase == PH_HALT)
        else $error("error report did not halt the parser");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |-> !o_res_valid)
        else $error("result emitted while halted");

    a_pay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAY |-> r_remaining != 31'd0)
        else $error("payload phase with nothing remaining");

endmodule

`default_nettype wire

// ===== rtl/lpfp_out_buf.sv =====
`default_nettype none

module lpfp_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lpfp_pkg::t_result i_push_data,
    output logic                 o_push_ready,
    output logic                 o_valid,
    input  wire logic            i_pop_ready,
    output lpfp_pkg::t_result    o_data
);
    import lpfp_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop        = r_main_valid && i_pop_ready;
    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_main_valid;
    assign o_data       = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // refill the output register from the skid stage
            if (w_pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || w_pop) begin
                n_main       = i_push_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_push_data;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid stage holds a request with the output register empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("request pushed while both stages are full");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_main_valid && !i_pop_ready))
        else $error("skid stage filled without an output stall");

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_frame_parser.sv =====
`default_nettype none

// Length-prefixed frame parser. Takes one stream byte per cycle while
// input ready is high and splits the stream into frames: a 4-byte
// big-endian length (counting the 16 header bytes), four header words
// (signature, compression word, server version, minimum version), then the
// payload. Each payload byte comes out as one request tagged with the
// compressed flag, the payload length and a last-byte mark. A bad length,
// a bad signature or a minimum version above own_version is reported once
// as an error request; the parser then drops bytes until an input with
// restart set. Throughput is one input byte per clock while input ready
// is high: the parser state updates in the accept cycle and the result is
// registered into the output buffer. A two-entry output buffer (output
// register plus skid) keeps input ready high while one result waits; input
// ready drops only while both entries are full. Configuration writes take
// effect on the next cycle and are meant for idle periods.
module length_prefixed_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte stream in
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    // result requests out
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [7:0]       o_payload_byte,
    output logic             o_last_byte,
    output logic             o_compressed,
    output logic [30:0]      o_payload_length,
    output logic [1:0]       o_error_code,
    output logic [31:0]      o_required_version,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import lpfp_pkg::*;

    logic    w_take;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    // accept a byte whenever the output buffer has room
    assign w_take = i_in_valid && o_in_ready;

    lpfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    lpfp_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_res_valid),
        .i_push_data  (w_res),
        .o_push_ready (o_in_ready),
        .o_valid      (o_out_valid),
        .i_pop_ready  (i_out_ready),
        .o_data       (w_out)
    );

    // unpack the held request onto the field ports
    assign o_result_kind      = w_out.result_kind;
    assign o_payload_byte     = w_out.payload_byte;
    assign o_last_byte        = w_out.last_byte;
    assign o_compressed       = w_out.compressed;
    assign o_payload_length   = w_out.payload_length;
    assign o_error_code       = w_out.error_code;
    assign o_required_version = w_out.required_version;

endmodule

`default_nettype wire
